FILE: rtl/jsu_pkg.sv
// types, codes and helpers shared by the json string unescaper
`default_nettype none

package jsu_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_STR  = 2'd1,
    MODE_ESC  = 2'd2,
    MODE_HEX  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_NO_QUOTE = 3'd1;
  localparam logic [2:0] ERR_CTRL     = 3'd2;
  localparam logic [2:0] ERR_ESCAPE   = 3'd3;
  localparam logic [2:0] ERR_HEX      = 3'd4;
  localparam logic [2:0] ERR_UNTERM   = 3'd5;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  // result of a hex digit lookup: valid flag and nibble
  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.nib = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.nib = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.nib = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.nib = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/json_string_unescaper.sv
// json string unescaper: decodes escapes and \u code points into utf-8 bytes
//
//  channel  dir  tdata (low bit up)                  tuser          tlast
//  s_axis   in   text_byte[7:0]                      text_end       -
//  m_axis   out  out_byte[7:0], error_code[10:8], 0  result_kind    last_of_run
//
// one request is decoded in the cycle it is taken; its 0 to 3 results go into
// a three-entry result register and leave one per cycle while m_tready is high
// a request is taken every cycle while its predecessor has no result left or its
// last one is taken, so a \u escape emitting three bytes holds the input until its third byte is taken
// rst clears the scan state and the result count; the string starts idle
// a stalled m side holds the result register and drops s_tready while any result is pending
`default_nettype none

module json_string_unescaper
  import jsu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // text_byte[7:0]
  input  wire logic        s_tuser,   // text_end
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // out_byte[7:0], error_code[10:8], zero[15:11]
  output logic [1:0]       m_tuser,   // result_kind[1:0]
  output logic             m_tlast    // last_of_run
);

  mode_t       mode, mode_next;
  logic [1:0]  hex_cnt, hex_cnt_next;
  logic [15:0] acc, acc_next;

  // result register
  logic [1:0]  rem, pos;
  kind_t       res_kind;
  logic [2:0]  res_err;
  logic [7:0]  res_b0, res_b1, res_b2;

  // decode of the current request
  logic [1:0]  dec_n;
  kind_t       dec_kind;
  logic [2:0]  dec_err;
  logic [7:0]  dec_b0, dec_b1, dec_b2;

  logic        s_take, m_take;
  logic [7:0]  head_byte;

  assign m_take   = m_tvalid && m_tready;
  assign s_tready = (rem == 2'd0) || (rem == 2'd1 && m_tready);
  assign s_take   = s_tvalid && s_tready;

  always_comb begin
    logic [7:0]  c;
    logic        fin;
    logic        fail;
    logic [2:0]  fail_code;
    hex_t        h;
    logic [15:0] cp;
    c            = s_tdata;
    fin          = s_tuser;
    fail         = 1'b0;
    fail_code    = ERR_NONE;
    h            = hex_decode(c);
    cp           = {acc[11:0], h.nib};
    mode_next    = mode;
    hex_cnt_next = hex_cnt;
    acc_next     = acc;
    dec_n        = 2'd0;
    dec_kind     = KIND_DATA;
    dec_err      = ERR_NONE;
    dec_b0       = 8'd0;
    dec_b1       = 8'd0;
    dec_b2       = 8'd0;
    case (mode)
      MODE_IDLE: begin
        if (fin || c != CH_QUOTE) begin
          fail      = 1'b1;
          fail_code = ERR_NO_QUOTE;
        end else begin
          mode_next = MODE_STR;
        end
      end
      MODE_STR: begin
        if (fin) begin
          fail      = 1'b1;
          fail_code = ERR_UNTERM;
        end else if (c == CH_QUOTE) begin
          mode_next = MODE_IDLE;
          dec_n     = 2'd1;
          dec_kind  = KIND_END;
        end else if (c < CH_SPACE) begin
          fail      = 1'b1;
          fail_code = ERR_CTRL;
        end else if (c == CH_BACKSLASH) begin
          mode_next = MODE_ESC;
        end else begin
          dec_n  = 2'd1;
          dec_b0 = c;
        end
      end
      MODE_ESC: begin
        mode_next = MODE_STR;
        dec_n     = 2'd1;
        if (fin) begin
          fail      = 1'b1;
          fail_code = ERR_ESCAPE;
        end else if (c inside {CH_QUOTE, CH_BACKSLASH, CH_SLASH}) begin
          dec_b0 = c;
        end else if (c == CH_B) begin
          dec_b0 = 8'h08;
        end else if (c == CH_F) begin
          dec_b0 = 8'h0C;
        end else if (c == CH_N) begin
          dec_b0 = 8'h0A;
        end else if (c == CH_R) begin
          dec_b0 = 8'h0D;
        end else if (c == CH_T) begin
          dec_b0 = 8'h09;
        end else if (c == CH_U) begin
          mode_next    = MODE_HEX;
          dec_n        = 2'd0;
          hex_cnt_next = 2'd0;
          acc_next     = 16'd0;
        end else begin
          fail      = 1'b1;
          fail_code = ERR_ESCAPE;
        end
      end
      MODE_HEX: begin
        if (fin || !h.ok) begin
          fail      = 1'b1;
          fail_code = ERR_HEX;
        end else if (hex_cnt == 2'd3) begin
          mode_next    = MODE_STR;
          hex_cnt_next = 2'd0;
          acc_next     = 16'd0;
          // utf-8 length from the top bits of the code point
          if (cp[15:7] == 9'd0) begin
            dec_n  = 2'd1;
            dec_b0 = cp[7:0];
          end else if (cp[15:11] == 5'd0) begin
            dec_n  = 2'd2;
            dec_b0 = {3'b110, cp[10:6]};
            dec_b1 = {2'b10, cp[5:0]};
          end else begin
            dec_n  = 2'd3;
            dec_b0 = {4'b1110, cp[15:12]};
            dec_b1 = {2'b10, cp[11:6]};
            dec_b2 = {2'b10, cp[5:0]};
          end
        end else begin
          acc_next     = cp;
          hex_cnt_next = hex_cnt + 2'd1;
        end
      end
      default: begin
        mode_next = MODE_IDLE;
      end
    endcase
    if (fail) begin
      mode_next    = MODE_IDLE;
      hex_cnt_next = 2'd0;
      acc_next     = 16'd0;
      dec_n        = 2'd1;
      dec_kind     = KIND_ERR;
      dec_err      = fail_code;
      dec_b0       = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_IDLE;
      hex_cnt <= 2'd0;
      acc     <= 16'd0;
    end else if (s_take) begin
      mode    <= mode_next;
      hex_cnt <= hex_cnt_next;
      acc     <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 2'd0;
      pos <= 2'd0;
    end else if (s_take) begin
      rem <= dec_n;
      pos <= 2'd0;
    end else if (m_take) begin
      rem <= rem - 2'd1;
      pos <= pos + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_take) begin
      res_kind <= dec_kind;
      res_err  <= dec_err;
      res_b0   <= dec_b0;
      res_b1   <= dec_b1;
      res_b2   <= dec_b2;
    end
  end

  always_comb begin
    case (pos)
      2'd0:    head_byte = res_b0;
      2'd1:    head_byte = res_b1;
      2'd2:    head_byte = res_b2;
      default: head_byte = 8'd0;
    endcase
  end

  assign m_tvalid = (rem != 2'd0);
  assign m_tdata  = {5'd0, res_err, head_byte};
  assign m_tuser  = res_kind;
  assign m_tlast  = (rem == 2'd1);

  // a finish or an error is always the only result of its request
  a_single_non_data: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != KIND_DATA) |-> m_tlast)
    else $error("end or error result not alone");

  // error code present exactly on error results
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tuser == KIND_ERR) == (m_tdata[10:8] != ERR_NONE)))
    else $error("error code does not match result kind");

  // a finish or an error sends the scanner back to idle with cleared state
  a_back_idle: assert property (@(posedge clk) disable iff (rst)
    (s_take && dec_n != 2'd0 && dec_kind != KIND_DATA) |=>
      (mode == MODE_IDLE && hex_cnt == 2'd0 && acc == 16'd0))
    else $error("scanner not idle after finish or error");

  // results never run past the three buffered bytes
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ({1'b0, pos} + {1'b0, rem} <= 3'd3))
    else $error("result index out of range");

endmodule

`default_nettype wire
